// ===== sv/ghal_pkg.sv =====
// ----------------------------------------------------------------------------
// ghal_pkg: shared types and codes of the generational handle allocator
// Request and result word layouts, operation codes and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ghal_pkg;

	// field widths of the request and result words
	localparam int unsigned OP_W     = 2;
	localparam int unsigned IDX_W    = 10;
	localparam int unsigned GEN_W    = 8;
	localparam int unsigned STATUS_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

	// request word
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] handle_index;
		logic [GEN_W-1:0] handle_gen;
	} req_t;

	// result word
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    out_index;
		logic [GEN_W-1:0]    out_gen;
		logic                alive;
	} rsp_t;

endpackage

// ===== sv/ghal_ram.sv =====
// ----------------------------------------------------------------------------
// ghal_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghal_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot/generation handle allocator
// Sequence: create from a fresh slot, on full or unknown op: result registered
//   at the accept; destroy and check: through S_CHK; create from the free
//   stack: through S_POP and S_GEN (stack read, then generation read).
// Throughput: next word accepted the cycle the result shows; the receiver
//   cannot stall. Reset: async, clears counters and FSM; a slot's generation
//   entry is zeroed as the fresh slot is handed out, so no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_allocator #(
	parameter int unsigned MAX_SLOTS = 1024,
	parameter int unsigned GEN_BITS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ghal_pkg::req_t req,
	output logic          done,
	output ghal_pkg::rsp_t result
);

	import ghal_pkg::*;

	// slot index, count and widened compare widths
	localparam int unsigned IW   = $clog2(MAX_SLOTS);
	localparam int unsigned CW   = $clog2(MAX_SLOTS + 1);
	localparam int unsigned XW   = (IW > IDX_W) ? IW : IDX_W;
	localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam int unsigned GCW  = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_GEN  = 4'b0100,
		S_CHK  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      depth_q;
	logic [CW-1:0]      fresh_q;
	logic [IDX_W-1:0]   idx_q;
	logic [GEN_W-1:0]   gen_q;
	logic               destroy_q;
	logic [IW-1:0]      slot_q;
	rsp_t               rsp_q;
	logic               done_q;

	logic               accept;
	logic [XW-1:0]      req_idx_ext;
	logic [XW-1:0]      idx_q_ext;
	logic [XW-1:0]      fresh_ext;
	logic [XW-1:0]      slot_ext;
	logic [GCW-1:0]     gen_rd_ext;
	logic [CW-1:0]      depth_dec;
	logic               live;
	logic               depth_room;
	logic               fresh_take;
	logic               chk_wr;
	logic               done_d;

	logic               gen_we;
	logic [IW-1:0]      gen_waddr;
	logic [GEN_BITS-1:0] gen_wdata;
	logic [IW-1:0]      gen_raddr;
	logic [GEN_BITS-1:0] gen_rdata;
	logic               stk_we;
	logic [IW-1:0]      stk_raddr;
	logic [IW-1:0]      stk_rdata;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	// width adaptation between the 10-bit field and the slot index
	assign req_idx_ext = XW'(req.handle_index);
	assign idx_q_ext   = XW'(idx_q);
	assign fresh_ext   = XW'(fresh_q);
	assign slot_ext    = XW'(slot_q);
	assign gen_rd_ext  = GCW'(gen_rdata);
	assign depth_dec   = depth_q - CW'(1);
	assign depth_room  = (depth_q < CW'(MAX_SLOTS));

	// handle live: index handed out and generation matches
	assign live = (CMPW'(idx_q) < CMPW'(fresh_q)) && (gen_rd_ext == GCW'(gen_q));

	// create served straight from the fresh-slot counter
	assign fresh_take = accept && (req.op == OP_CREATE) && (depth_q == '0)
		&& (fresh_q < CW'(MAX_SLOTS));
	assign chk_wr     = (state_q == S_CHK) && destroy_q && live;

	// result strobe: requests answered at once at accept, others at their last step
	assign done_d = (accept && ((req.op == OP_CREATE && depth_q == '0)
		|| (req.op != OP_CREATE && req.op != OP_DESTROY && req.op != OP_CHECK)))
		|| (state_q == S_GEN) || (state_q == S_CHK);

	// memory addressing: reads are issued in the accept cycle, but a pop's generation read in S_POP
	assign stk_raddr = depth_dec[IW-1:0];
	assign gen_raddr = (state_q == S_POP) ? stk_rdata : req_idx_ext[IW-1:0];
	// generation write: zero on first hand-out, bump on a live destroy
	assign gen_we    = chk_wr || fresh_take;
	assign gen_waddr = fresh_take ? fresh_q[IW-1:0] : idx_q_ext[IW-1:0];
	assign gen_wdata = fresh_take ? '0 : gen_rdata + GEN_BITS'(1);
	assign stk_we    = chk_wr && depth_room;

	ghal_ram #(
		.WIDTH (GEN_BITS),
		.DEPTH (MAX_SLOTS)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	ghal_ram #(
		.WIDTH (IW),
		.DEPTH (MAX_SLOTS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[IW-1:0]),
		.wdata (idx_q_ext[IW-1:0]),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// control: sequencer, stack depth and fresh-slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			fresh_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= done_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.op)
							OP_CREATE: begin
								priority if (depth_q != '0) begin
									depth_q <= depth_dec;
									state_q <= S_POP;
								end else if (fresh_q < CW'(MAX_SLOTS)) begin
									fresh_q <= fresh_q + CW'(1);
								end else begin
									// full: nothing changes
								end
							end
							OP_DESTROY, OP_CHECK: begin
								state_q <= S_CHK;
							end
							default: begin
								// unknown op: answered at once
							end
						endcase
					end
				end
				S_POP: begin
					state_q <= S_GEN;
				end
				S_GEN: begin
					state_q <= S_IDLE;
				end
				S_CHK: begin
					if (stk_we) begin
						depth_q <= depth_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: request capture and result word
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_q     <= req.handle_index;
					gen_q     <= req.handle_gen;
					destroy_q <= (req.op == OP_DESTROY);
					// a fresh slot's generation is cleared as it is handed out
					priority if (fresh_take) begin
						rsp_q <= '{status: ST_OK, out_index: fresh_ext[IDX_W-1:0],
							out_gen: '0, alive: 1'b0};
					end else if (req.op != OP_CREATE) begin
						rsp_q <= '{status: ST_STALE, out_index: '0, out_gen: '0,
							alive: 1'b0};
					end else begin
						rsp_q <= '{status: ST_FULL, out_index: '0, out_gen: '0,
							alive: 1'b0};
					end
				end
			end
			S_POP: begin
				slot_q <= stk_rdata;
			end
			S_GEN: begin
				rsp_q <= '{status: ST_OK, out_index: slot_ext[IDX_W-1:0],
					out_gen: gen_rd_ext[GEN_W-1:0], alive: 1'b0};
			end
			S_CHK: begin
				rsp_q <= '{status: live ? ST_OK : ST_STALE, out_index: '0,
					out_gen: '0, alive: live};
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	// a result only shows once the sequencer is back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// free stack never holds more entries than slots
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CW'(MAX_SLOTS))
		else $error("free stack depth overflow");

	// fresh-slot counter never passes the slot count
	a_fresh_max: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CW'(MAX_SLOTS))
		else $error("fresh slot counter overflow");

	// a stack pop always runs into the generation read and then a result
	a_pop_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> (state_q == S_GEN) ##1 done)
		else $error("pop sequence broken");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the generational handle allocator
// Runs a directed table of requests, then random request streams: a short
// free-running mix, a pass that uses up every slot and asks for more, and a
// closing mix on the full allocator. A behavioural model predicts each
// result word not pinned in the table, and result words are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import ghal_pkg::*;

	localparam int unsigned SLOTS       = 1024;
	localparam int unsigned PRE_WORDS   = 40;
	localparam int unsigned TAIL_WORDS  = 30;
	localparam int unsigned MAX_GAP     = 13;
	localparam int unsigned DRAIN_LIMIT = 1000;
	localparam int unsigned SETTLE      = 4;
	localparam int unsigned LOUD_LIMIT  = 40;

	// op code the block does not decode
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

	// one row of the directed table; pinned rows carry a hand-typed result
	typedef struct {
		req_t w;
		bit   pinned;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t result;

	// allocator model state
	logic [GEN_W-1:0] gen_mem   [SLOTS];
	logic [IDX_W-1:0] free_lifo [SLOTS];
	int unsigned      free_depth;
	int unsigned      fresh_cnt;

	rsp_t        pending_q[$];
	plan_row_t   plan[$];
	int unsigned words_taken;
	int unsigned errors;
	bit          pin_valid;
	rsp_t        pin_rsp;
	bit          stall_free;

	generational_handle_allocator #(
		.MAX_SLOTS(SLOTS),
		.GEN_BITS (GEN_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= LOUD_LIMIT) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
	endtask

	// model of one request: updates the slot state, returns the result word
	function automatic rsp_t predict_word(input req_t w);
		rsp_t        r;
		int unsigned idx;
		logic        live;
		r        = '0;
		r.status = ST_STALE;
		idx      = 32'(w.handle_index);
		live     = (idx < fresh_cnt) && (gen_mem[idx] == w.handle_gen);
		case (w.op)
			OP_CREATE: begin
				r.status = ST_OK;
				// recycled slots first, newest on top
				if (free_depth > 0) begin
					free_depth--;
					r.out_index = free_lifo[free_depth];
				end else if (fresh_cnt < SLOTS) begin
					r.out_index = IDX_W'(fresh_cnt);
					fresh_cnt++;
				end else begin
					r.status = ST_FULL;
				end
				if (r.status == ST_OK) r.out_gen = gen_mem[r.out_index];
			end
			OP_DESTROY: begin
				if (live) begin
					gen_mem[idx] = gen_mem[idx] + GEN_W'(1);
					// push is dropped once the stack is full
					if (free_depth < SLOTS) begin
						free_lifo[free_depth] = IDX_W'(idx);
						free_depth++;
					end
					r.status = ST_OK;
					r.alive  = 1'b1;
				end
			end
			OP_CHECK: begin
				if (live) begin
					r.status = ST_OK;
					r.alive  = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// random request: create with the given weight, else destroy/check,
	// mostly on live handles, sometimes stale, never handed out or undecoded
	function automatic req_t random_word(input int unsigned create_pct);
		req_t        w;
		int unsigned roll;
		w.op           = OP_CREATE;
		w.handle_index = IDX_W'($urandom);
		w.handle_gen   = GEN_W'($urandom);
		roll           = $urandom_range(0, 99);
		if (roll >= create_pct) begin
			w.op = ($urandom_range(0, 1) == 1) ? OP_DESTROY : OP_CHECK;
			if ($urandom_range(0, 29) == 0) w.op = OP_UNDEF;
			if (fresh_cnt > 0 && $urandom_range(0, 3) != 0) begin
				w.handle_index = IDX_W'($urandom_range(0, fresh_cnt - 1));
				w.handle_gen   = gen_mem[w.handle_index];
				if ($urandom_range(0, 5) == 0) begin
					w.handle_gen = w.handle_gen + GEN_W'($urandom_range(1, 255));
				end
			end else if (fresh_cnt < SLOTS && $urandom_range(0, 1) == 0) begin
				// slot not handed out yet, generation as stored
				w.handle_index = IDX_W'($urandom_range(fresh_cnt, SLOTS - 1));
				w.handle_gen   = '0;
			end
		end
		return w;
	endfunction

	function automatic void add_row(
		input logic [OP_W-1:0]     op,
		input int unsigned         idx,
		input int unsigned         gen,
		input bit                  pinned = 1'b0,
		input logic [STATUS_W-1:0] st     = ST_OK,
		input int unsigned         oidx   = 0,
		input int unsigned         ogen   = 0,
		input bit                  alive  = 1'b0
	);
		plan_row_t r;
		r.w.op           = op;
		r.w.handle_index = IDX_W'(idx);
		r.w.handle_gen   = GEN_W'(gen);
		r.pinned         = pinned;
		r.want.status    = st;
		r.want.out_index = IDX_W'(oidx);
		r.want.out_gen   = GEN_W'(ogen);
		r.want.alive     = alive;
		plan.push_back(r);
	endfunction

	// one request word: random idle gap unless in a stall-free run, then hold until taken
	task automatic send_word(input req_t w, input bit pinned, input rsp_t want);
		int unsigned gap;
		int unsigned seen;
		gap = stall_free ? 0 : $urandom_range(0, MAX_GAP);
		if ($urandom_range(0, 49) == 0) stall_free = !stall_free;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pin_valid = pinned;
		pin_rsp   = want;
		req       = w;
		start     = 1'b1;
		seen      = words_taken;
		do @(negedge clk); while (words_taken == seen);
	endtask

	// result check first, then record any word taken at this edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				report_mismatch("result word with nothing outstanding");
			end else begin
				want = pending_q.pop_front();
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status, want.status));
				if (result.out_index !== want.out_index)
					report_mismatch($sformatf("out_index %0d, expected %0d",
						result.out_index, want.out_index));
				if (result.out_gen !== want.out_gen)
					report_mismatch($sformatf("out_gen %0d, expected %0d",
						result.out_gen, want.out_gen));
				if (result.alive !== want.alive)
					report_mismatch($sformatf("alive %0b, expected %0b",
						result.alive, want.alive));
			end
		end
		if (arst_n && start && !busy) begin
			want = predict_word(req);
			if (pin_valid) want = pin_rsp;
			pending_q.push_back(want);
			words_taken++;
		end
	end

	initial begin
		int unsigned guard;

		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		pin_valid   = 1'b0;
		pin_rsp     = '0;
		stall_free  = 1'b0;
		words_taken = 0;
		errors      = 0;
		free_depth  = 0;
		fresh_cnt   = 0;
		foreach (gen_mem[i]) begin
			gen_mem[i]   = '0;
			free_lifo[i] = '0;
		end

		// directed table
		add_row(OP_CHECK,   0,    0,   1'b1, ST_STALE);
		add_row(OP_DESTROY, 0,    0,   1'b1, ST_STALE);
		add_row(OP_UNDEF,   1023, 255, 1'b1, ST_STALE);
		add_row(OP_CREATE,  1023, 255, 1'b1, ST_OK, 0, 0);
		add_row(OP_CREATE,  0,    0,   1'b1, ST_OK, 1, 0);
		add_row(OP_CHECK,   0,    0,   1'b1, ST_OK, 0, 0, 1'b1);
		add_row(OP_CHECK,   1023, 255, 1'b1, ST_STALE);
		add_row(OP_CHECK,   0,    255, 1'b1, ST_STALE);
		add_row(OP_DESTROY, 0,    1,   1'b1, ST_STALE);
		add_row(OP_DESTROY, 0,    0,   1'b1, ST_OK, 0, 0, 1'b1);
		add_row(OP_CHECK,   0,    0,   1'b1, ST_STALE);
		add_row(OP_CHECK,   0,    1,   1'b1, ST_OK, 0, 0, 1'b1);
		add_row(OP_DESTROY, 0,    1,   1'b1, ST_OK, 0, 0, 1'b1);
		add_row(OP_CREATE,  0,    0,   1'b1, ST_OK, 0, 2);
		add_row(OP_CREATE,  0,    0,   1'b1, ST_OK, 0, 2);
		add_row(OP_CREATE,  512,  128, 1'b1, ST_OK, 2, 0);
		add_row(OP_DESTROY, 1,    0);
		add_row(OP_CHECK,   1,    1);
		add_row(OP_CREATE,  0,    0);
		add_row(OP_CHECK,   2,    0);
		add_row(OP_UNDEF,   0,    0,   1'b1, ST_STALE);
		add_row(OP_DESTROY, 2,    0);
		add_row(OP_CHECK,   3,    0);

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) send_word(plan[i].w, plan[i].pinned, plan[i].want);

		// short free-running mix
		repeat (PRE_WORDS) send_word(random_word(45), 1'b0, '0);

		// use up every slot, then ask for more
		while (free_depth > 0 || fresh_cnt < SLOTS) send_word(random_word(100), 1'b0, '0);
		repeat (4) send_word(random_word(100), 1'b0, '0);

		// mix on the full allocator: frees and re-creates
		repeat (TAIL_WORDS) send_word(random_word(50), 1'b0, '0);
		start = 1'b0;

		// drain outstanding results, then watch for strays
		guard = 0;
		while (pending_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_q.size() != 0) report_mismatch("result words never arrived");

		if (errors == 0) begin
			$display("PASS generational_handle_allocator");
		end else begin
			$display("FAIL generational_handle_allocator");
		end
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("FAIL generational_handle_allocator");
		$finish;
	end

endmodule
